// File: hdl/pss_pkg.sv
// Shared constants and codes for the plucked string voice.
// No dependencies; imported by the voice top level, the checker and the testbench.
`default_nettype none

package pss_pkg;

    // Default delay line depth in samples.
    localparam int MAX_PERIOD_DEF = 256;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int LEN_W    = 9;
    localparam int OUT_W    = 15;

    // Q1.15 limits.
    localparam logic [SAMPLE_W-1:0] Q15_ONE    = 16'd32768;
    localparam logic [OUT_W-1:0]    SAMPLE_MAX = 15'd32767;

    // Request kinds.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PERIOD = 2'd0;
    localparam logic [1:0] CFG_DECAY  = 2'd1;
    localparam logic [1:0] CFG_GAIN   = 2'd2;

    // Configuration reset values.
    localparam logic [LEN_W-1:0] PERIOD_RST = 9'd147;
    localparam logic [CFG_W-1:0] DECAY_RST  = 16'd65529;
    localparam logic [CFG_W-1:0] GAIN_RST   = 16'd3482;

endpackage

`default_nettype wire

// File: hdl/plucked_string_synth_voice_top.sv
// Karplus-Strong plucked string voice: delay line RAM, tick sequencer and output register.
// Depends on pss_pkg and pss_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries req_type and noise_value. A start
//   transfer rewinds the position and clears the previous sample. A load transfer
//   writes one saturated noise value at the position and advances it. A tick
//   transfer reads the entry, averages it with the previous sample, scales by
//   decay, writes it back and advances; the result, scaled by gain and saturated,
//   appears on the output channel (out_valid/out_ready) as sample and clipped.
//   Start and load transfers finish in the cycle they are taken; the next item
//   may follow in the next cycle. A tick raises out_valid after these steps from its
//   input transfer: the RAM read happens at the transfer edge, then the decay
//   multiply (ST_AVG), the write-back and gain multiply (ST_SCALE) and the
//   load of the output register (ST_OUT). Ticks run one at a time through this
//   sequence and the next item is taken only after the tick returns to idle.
//   While a result waits in the output register, the next item is still
//   taken; a following tick holds in its last step until the output register is
//   free. Reset clears the position, the previous sample and the output register
//   and restores the configuration defaults; the delay line is not cleared and
//   must be loaded before ticking.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`default_nettype none

module plucked_string_synth_voice_top
    import pss_pkg::*;
#(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          req_type,
    input  wire logic [SAMPLE_W-1:0] noise_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [OUT_W-1:0]         sample,
    output logic                     clipped
);

    localparam int POS_W = $clog2(MAX_PERIOD);
    // Compare width that holds both the period register and MAX_PERIOD.
    localparam int CW = (POS_W + 1 > LEN_W + 1) ? POS_W + 1 : LEN_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AVG,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [LEN_W-1:0]      period_reg;
    logic [CFG_W-1:0]      decay_reg;
    logic [CFG_W-1:0]      gain_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [SAMPLE_W-1:0]   prev_reg;
    logic [SAMPLE_W-1:0]   v_reg;
    logic [31:0]           prod_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      sample_reg;
    logic                  clipped_reg;

    logic                  in_xfer;
    logic                  tick_go;
    logic                  load_go;
    logic [CW-1:0]         pos_inc;
    logic [CW-1:0]         len_eff;
    logic [SAMPLE_W-1:0]   noise_sat;
    logic [SAMPLE_W:0]     sum;
    logic [31:0]           decay_prod;
    logic                  ram_we;
    logic [SAMPLE_W-1:0]   ram_wdata;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic                  out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign tick_go  = in_xfer && (req_type == REQ_TICK);
    assign load_go  = in_xfer && (req_type == REQ_LOAD);
    assign out_free = !out_valid_reg || out_ready;

    // Position advance with the period clamped to the legal range.
    always_comb
    begin
        pos_inc = CW'(pos_reg) + CW'(1);
        if (CW'(period_reg) < CW'(2))
        begin
            len_eff = CW'(2);
        end
        else if (CW'(period_reg) > CW'(MAX_PERIOD))
        begin
            len_eff = CW'(MAX_PERIOD);
        end
        else
        begin
            len_eff = CW'(period_reg);
        end
        if (pos_inc >= len_eff)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_inc[POS_W-1:0];
        end
    end

    assign noise_sat  = (noise_value > Q15_ONE) ? Q15_ONE : noise_value;
    assign sum        = {1'b0, ram_rdata} + {1'b0, prev_reg};
    assign decay_prod = 32'(sum[SAMPLE_W:1]) * 32'(decay_reg);

    // The write port serves load items and the write-back step of a tick.
    assign ram_we    = load_go || (state_reg == ST_SCALE);
    assign ram_wdata = (state_reg == ST_SCALE) ? v_reg : noise_sat;

    pss_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_PERIOD)
    ) u_delay (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (pos_reg),
        .wr_data (ram_wdata),
        .rd_en   (tick_go),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_RST;
            decay_reg     <= DECAY_RST;
            gain_reg      <= GAIN_RST;
            pos_reg       <= '0;
            prev_reg      <= '0;
            v_reg         <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            clipped_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PERIOD: period_reg <= cfg_data[LEN_W-1:0];
                    CFG_DECAY:  decay_reg  <= cfg_data;
                    CFG_GAIN:   gain_reg   <= cfg_data;
                    default:    ;
                endcase
            end

            // In the output step the valid flag is handled below.
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        unique case (req_type)
                            REQ_START:
                            begin
                                pos_reg  <= '0;
                                prev_reg <= '0;
                            end
                            REQ_LOAD:
                            begin
                                pos_reg <= pos_next;
                            end
                            REQ_TICK:
                            begin
                                state_reg <= ST_AVG;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_AVG:
                begin
                    v_reg     <= decay_prod[31:16];
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    prev_reg  <= v_reg;
                    pos_reg   <= pos_next;
                    prod_reg  <= 32'(v_reg) * 32'(gain_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        // Result is prod >> 12; anything above bit 26 exceeds 32767.
                        if (prod_reg[31:27] != 5'd0)
                        begin
                            sample_reg  <= SAMPLE_MAX;
                            clipped_reg <= 1'b1;
                        end
                        else
                        begin
                            sample_reg  <= prod_reg[26:12];
                            clipped_reg <= 1'b0;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign clipped   = clipped_reg;

`ifndef SYNTH
    // The position never leaves the delay line.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(pos_reg) < CW'(MAX_PERIOD))
        else $error("position beyond delay line depth");

    // A tick reaches the output step after its read and two multiply steps.
    a_tick_seq: assert property (@(posedge clk) disable iff (!rst_n)
        tick_go |=> ##2 (state_reg == ST_OUT))
        else $error("tick sequence out of order");

    // The decayed value stays within Q1.15 below one.
    a_v_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |-> (v_reg[SAMPLE_W-1] == 1'b0))
        else $error("decayed value out of range");

    // While a tick is in flight, the RAM is written only in its write-back step.
    a_ram_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != ST_IDLE)) |-> (state_reg == ST_SCALE))
        else $error("unexpected delay line write");

    // A clipped result always carries the saturation value.
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clipped_reg) |-> (sample_reg == SAMPLE_MAX))
        else $error("clipped sample not saturated");
`endif

endmodule

`default_nettype wire

// File: hdl/pss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module pss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: tb/pluck_voice_checker.sv
// Checker for the plucked string voice: watches the configuration port and both channels,
// keeps its own copy of the delay line and predicts every tick result. Depends on pss_pkg.
module pluck_voice_checker
    import pss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [1:0]          req_type,
    input  wire logic [SAMPLE_W-1:0] noise_value,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic [OUT_W-1:0]    sample,
    input  wire logic                clipped,
    output int                       mismatches,
    output int                       awaited
);

    typedef struct packed {
        logic [OUT_W-1:0] level;
        logic             clip;
    } voice_out_t;

    voice_out_t expected_samples[$];

    logic [LEN_W-1:0]    len_r   = PERIOD_RST;
    logic [CFG_W-1:0]    decay_r = DECAY_RST;
    logic [CFG_W-1:0]    gain_r  = GAIN_RST;
    logic [SAMPLE_W-1:0] wave [MAX_PERIOD_DEF];
    logic [SAMPLE_W-1:0] last_v  = '0;
    int unsigned         pos     = 0;
    int                  fails   = 0;

    always @(posedge clk) begin : watch
        logic [16:0] mean;
        logic [32:0] scaled;
        logic [15:0] fresh;
        logic [31:0] loud;
        voice_out_t  want;
        int unsigned span;
        int unsigned nxt;

        if (!rst_n)
        begin
            len_r   = PERIOD_RST;
            decay_r = DECAY_RST;
            gain_r  = GAIN_RST;
            last_v  = '0;
            pos     = 0;
            fails   = 0;
            expected_samples.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PERIOD: len_r   = cfg_data[LEN_W-1:0];
                    CFG_DECAY:  decay_r = cfg_data;
                    CFG_GAIN:   gain_r  = cfg_data;
                    default:    ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                case (req_type)
                    REQ_START:
                    begin
                        pos    = 0;
                        last_v = '0;
                    end
                    REQ_LOAD:
                    begin
                        wave[pos] = (noise_value > Q15_ONE) ? Q15_ONE : noise_value;
                    end
                    REQ_TICK:
                    begin
                        mean   = ({1'b0, wave[pos]} + {1'b0, last_v}) >> 1;
                        scaled = 33'(mean) * 33'(decay_r);
                        fresh  = scaled[31:16];
                        wave[pos] = fresh;
                        last_v    = fresh;
                        loud   = 32'(fresh) * 32'(gain_r);
                        if (loud[31:12] > 20'(SAMPLE_MAX))
                        begin
                            want.level = SAMPLE_MAX;
                            want.clip  = 1'b1;
                        end
                        else
                        begin
                            want.level = loud[12 +: OUT_W];
                            want.clip  = 1'b0;
                        end
                        expected_samples.push_back(want);
                    end
                    default: ;
                endcase

                // A position left beyond a shortened length is still used once, then wraps.
                if (req_type == REQ_LOAD || req_type == REQ_TICK)
                begin
                    span = (len_r < 2) ? 2 :
                           (int'(len_r) > MAX_PERIOD_DEF) ? MAX_PERIOD_DEF : int'(len_r);
                    nxt  = pos + 1;
                    pos  = (nxt >= span) ? 0 : nxt;
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected result: sample %0d, clipped %0d", sample, clipped);
                    fails++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want.level)
                    begin
                        $error("sample: expected %0d, actual %0d", want.level, sample);
                        fails++;
                    end
                    if (clipped !== want.clip)
                    begin
                        $error("clipped: expected %0d, actual %0d", want.clip, clipped);
                        fails++;
                    end
                end
            end
        end

        mismatches <= fails;
        awaited    <= expected_samples.size();
    end

endmodule

// File: tb/tb_plucked_string_synth_voice_top.sv
// Testbench top for the plucked string voice: clock, reset, stimulus and verdict.
// Depends on pss_pkg, the voice RTL and pluck_voice_checker.
module tb_plucked_string_synth_voice_top;
    import pss_pkg::*;

    // Request kind the block ignores and register index it does not decode.
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         ITEM_BUDGET = 520;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [1:0]          cfg_index   = CFG_PERIOD;
    logic [CFG_W-1:0]    cfg_data    = '0;
    logic                in_valid    = 1'b0;
    logic [1:0]          req_type    = REQ_START;
    logic [SAMPLE_W-1:0] noise_value = '0;
    logic                out_ready   = 1'b0;
    wire logic           in_ready;
    wire logic           out_valid;
    wire logic [OUT_W-1:0] sample;
    wire logic           clipped;

    int mismatches;
    int awaited;
    bit steady = 1'b0;
    int sent   = 0;
    int quiet  = 0;

    // Position and written entries, tracked so that no tick reads an entry never loaded.
    int         pos_sh = 0;
    logic [8:0] len_sh = PERIOD_RST;
    bit         loaded [MAX_PERIOD_DEF];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    plucked_string_synth_voice_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .noise_value (noise_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .clipped     (clipped)
    );

    pluck_voice_checker voice_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .noise_value (noise_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .clipped     (clipped),
        .mismatches  (mismatches),
        .awaited     (awaited)
    );

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 16);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet == STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic int clamp_len(input logic [8:0] p);
        if (p < 2)
            return 2;
        if (int'(p) > MAX_PERIOD_DEF)
            return MAX_PERIOD_DEF;
        return int'(p);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_noise();
        case ($urandom_range(9))
            0:       return '0;
            1:       return Q15_ONE;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    // Valid stays up from one transfer to the next unless an idle cycle is drawn.
    task automatic send_item(input logic [1:0] kind, input logic [SAMPLE_W-1:0] nv);
        if (!steady)
        begin
            while ($urandom_range(99) < 16)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        noise_value <= nv;
        do
            @(posedge clk);
        while (!in_ready);

        if (kind == REQ_START)
            pos_sh = 0;
        if (kind == REQ_LOAD)
            loaded[pos_sh] = 1'b1;
        if (kind == REQ_LOAD || kind == REQ_TICK)
            pos_sh = (pos_sh + 1 >= clamp_len(len_sh)) ? 0 : pos_sh + 1;
        if (kind != REQ_UNUSED)
            sent++;
    endtask

    task automatic send_random();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
        begin
            if (loaded[pos_sh])
                send_item(REQ_TICK, 16'($urandom));
            else
                send_item(REQ_LOAD, pick_noise());
        end
        else if (roll < 85)
            send_item(REQ_LOAD, pick_noise());
        else if (roll < 95)
            send_item(REQ_START, 16'($urandom));
        else
            send_item(REQ_UNUSED, 16'($urandom));
    endtask

    // Drain the block, reprogram all registers, optionally start and fill the string, then send random items.
    task automatic run_phase(input logic [8:0] len, input logic [CFG_W-1:0] dk,
                             input logic [CFG_W-1:0] gn, input int body, input bit fill);
        int n;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
        repeat (8) @(posedge clk);

        cfg_we    <= 1'b1;
        cfg_index <= CFG_PERIOD;
        cfg_data  <= {7'($urandom), len};
        @(posedge clk);
        cfg_index <= CFG_DECAY;
        cfg_data  <= dk;
        @(posedge clk);
        cfg_index <= CFG_GAIN;
        cfg_data  <= gn;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        len_sh = len;

        if (fill)
        begin
            send_item(REQ_START, 16'($urandom));
            for (n = 0; n < clamp_len(len); n++)
                send_item(REQ_LOAD, pick_noise());
        end
        for (n = 0; n < body; n++)
            send_random();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration.
        send_item(REQ_START, 16'hFFFF);
        send_item(REQ_LOAD, 16'd0);
        send_item(REQ_LOAD, Q15_ONE);
        send_item(REQ_LOAD, 16'hFFFF);
        send_item(REQ_LOAD, 16'd32769);
        send_item(REQ_LOAD, 16'd32767);
        send_item(REQ_LOAD, 16'h5555);
        send_item(REQ_UNUSED, 16'hAAAA);
        send_item(REQ_START, 16'h0000);
        repeat (6) send_item(REQ_TICK, 16'h0000);
        send_item(REQ_UNUSED, 16'hFFFF);
        send_item(REQ_START, 16'h0000);
        send_item(REQ_TICK, 16'hFFFF);
        send_item(REQ_TICK, 16'h0000);
        send_item(REQ_LOAD, 16'd1);
        send_item(REQ_START, 16'h0000);
        send_item(REQ_TICK, 16'h0000);

        // Extremes of every register, then random settings.
        run_phase(9'd2, 16'hFFFF, 16'hFFFF, 30, 1'b1);
        run_phase(9'd3, 16'h0000, 16'h0000, 20, 1'b1);
        run_phase(9'd0, 16'($urandom), 16'($urandom), 20, 1'b1);
        run_phase(9'd1, 16'($urandom), 16'($urandom_range(8192)), 20, 1'b0);
        steady = 1'b1;
        run_phase(9'd256, DECAY_RST, 16'd4096, 60, 1'b1);
        run_phase(9'd511, 16'($urandom_range(65535, 60000)), 16'hFFFF, 40, 1'b0);
        steady = 1'b0;
        // The position is most likely far beyond this length here.
        run_phase(9'd5, 16'($urandom), 16'($urandom), 30, 1'b0);
        while (sent < ITEM_BUDGET)
        begin
            run_phase(9'($urandom_range(2, 24)),
                      16'($urandom_range(1) ? $urandom : $urandom_range(65535, 60000)),
                      16'($urandom_range(3) == 0 ? $urandom : $urandom_range(8192)),
                      $urandom_range(20, 60), $urandom_range(1) == 1);
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
